FILE: sv/dotn_pkg.sv
// ----------------------------------------------------------------------------
// dotn_pkg
// Shared types and constants for the door open timeout notifier.
// ----------------------------------------------------------------------------
package dotn_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int RX_FRAME_LEN_DEF = 8;

  // results one request can cause
  localparam int NRES   = 8;
  localparam int NRES_W = 4;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_EN  = 8'd1;
  localparam logic [15:0]          TIMEOUT_RESET = 16'd10000;

  // frame bytes
  localparam logic [7:0] SYNC_BYTE   = 8'h69;
  localparam logic [7:0] NOTIFY_CMD  = 8'h10;
  localparam logic [7:0] NOTIFY_LENH = 8'h00;
  localparam logic [7:0] NOTIFY_LENL = 8'h04;
  localparam logic [7:0] DOOR_ID     = 8'h01;
  localparam logic [7:0] REQ_CMD     = 8'h04;
  localparam logic [7:0] REQ_ARG     = 8'h01;
  localparam logic [7:0] EMPTY_CMD   = 8'h04;
  localparam logic [7:0] EMPTY_ARG   = 8'h00;
  localparam logic [15:0] OPEN_MAX   = 16'hFFFF;

  // door modes
  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_TIMED  = 2'd2
  } mode_t;

  // frame to send for one request
  typedef enum logic [1:0] {
    FRM_NONE   = 2'd0,
    FRM_NOTIFY = 2'd1,
    FRM_EMPTY  = 2'd2
  } frame_t;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // one result item
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       alarm_on;
    logic [1:0] door_status;
    logic       record_dropped;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

FILE: sv/door_open_timeout_notifier_top.sv
// ----------------------------------------------------------------------------
// door_open_timeout_notifier_top
// Door open timer with notify frames, duration queue and request parser.
// ----------------------------------------------------------------------------
// A request that causes one result (a tick with nothing to send, or a
// received byte) is taken every clock cycle unless the output stalls. A
// request that sends a frame fills a row of eight result cells (three for
// an empty answer) that drains one cell per cycle into the output register
// while the output is not held, so the next request is taken once the row
// is down to its last cell. Durations are held in a row of QUEUE_DEPTH
// cells that shifts toward the head on each pop.
module door_open_timeout_notifier_top #(
  parameter int QUEUE_DEPTH  = dotn_pkg::QUEUE_DEPTH_DEF,
  parameter int RX_FRAME_LEN = dotn_pkg::RX_FRAME_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic                           door_open,
  input  logic [7:0]                     rx_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           tx_valid,
  output logic [7:0]                     tx_byte,
  output logic                           tx_last,
  output logic                           alarm_on,
  output logic [1:0]                     door_status,
  output logic                           record_dropped,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dotn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dotn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dotn_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int RPW = $clog2(RX_FRAME_LEN);

  // configuration registers
  logic [15:0] timeout_ms;
  logic        alarm_enable;

  // door and receive state
  mode_t          door_mode, door_mode_next;
  logic [15:0]    open_time, open_time_next;
  logic           alarm_level, alarm_level_next;
  logic [RPW-1:0] rx_position, rx_position_next;
  logic [7:0]     rx_second_byte, rx_second_byte_next;
  logic [7:0]     rx_third_byte, rx_third_byte_next;
  logic [QCW-1:0] q_count;

  // per-request decisions
  logic        in_fire, adv;
  logic        push_req, pop, push, dropped;
  logic [15:0] dur, ot_inc;
  frame_t      frame;

  // queue row
  logic [QUEUE_DEPTH-1:0] q_vld;
  logic [15:0]            q_data [QUEUE_DEPTH];

  // result row
  logic [NRES-1:0]  res_vld;
  logic [RES_W-1:0] res_data [NRES];
  res_t             res_load [NRES];
  logic [NRES_W-1:0] nres;
  logic [7:0]       bytes [NRES];

  // output register
  res_t out_res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = !res_vld[1] && (!res_vld[0] || adv);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms   <= TIMEOUT_RESET;
      alarm_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMEOUT:  timeout_ms   <= cfg_data;
        REG_ALARM_EN: alarm_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state for door timer and frame parser
  always_comb begin
    door_mode_next      = door_mode;
    open_time_next      = open_time;
    alarm_level_next    = alarm_level;
    rx_position_next    = rx_position;
    rx_second_byte_next = rx_second_byte;
    rx_third_byte_next  = rx_third_byte;
    push_req            = 1'b0;
    pop                 = 1'b0;
    frame               = FRM_NONE;
    dur                 = open_time;
    ot_inc              = (open_time != OPEN_MAX) ? open_time + 16'd1 : open_time;
    if (!kind) begin
      case (door_mode)
        MODE_OPEN: begin
          open_time_next = ot_inc;
          dur            = ot_inc;
          if (door_open) begin
            if (ot_inc > timeout_ms) begin
              push_req       = 1'b1;
              frame          = FRM_NOTIFY;
              door_mode_next = MODE_TIMED;
              if (alarm_enable) begin
                alarm_level_next = 1'b1;
              end
            end
          end else if (ot_inc <= timeout_ms) begin
            push_req       = 1'b1;
            frame          = FRM_NOTIFY;
            door_mode_next = MODE_CLOSED;
          end
        end
        MODE_TIMED: begin
          if (!door_open) begin
            door_mode_next = MODE_CLOSED;
          end
          alarm_level_next = alarm_enable;
        end
        default: begin
          door_mode_next   = door_open ? MODE_OPEN : MODE_CLOSED;
          alarm_level_next = 1'b0;
          if (door_open) begin
            open_time_next = '0;
          end
        end
      endcase
    end else if (rx_position == '0) begin
      if (rx_byte == SYNC_BYTE) begin
        rx_position_next = RPW'(1);
      end
    end else begin
      if (rx_position == RPW'(1)) begin
        rx_second_byte_next = rx_byte;
      end
      if (rx_position == RPW'(2)) begin
        rx_third_byte_next = rx_byte;
      end
      if (rx_position == RPW'(RX_FRAME_LEN - 1)) begin
        rx_position_next = '0;
        if (rx_second_byte_next == REQ_CMD && rx_third_byte_next == REQ_ARG) begin
          if (q_count == '0) begin
            frame = FRM_EMPTY;
          end else begin
            pop   = 1'b1;
            frame = FRM_NOTIFY;
            dur   = q_data[0];
          end
        end
      end else begin
        rx_position_next = rx_position + RPW'(1);
      end
    end
  end

  assign dropped = push_req && (q_count == QCW'(QUEUE_DEPTH));
  assign push    = push_req && !dropped;

  // frame contents and result words
  always_comb begin
    bytes[0] = SYNC_BYTE;
    bytes[1] = NOTIFY_CMD;
    bytes[2] = NOTIFY_LENH;
    bytes[3] = NOTIFY_LENL;
    bytes[4] = DOOR_ID;
    bytes[5] = dur[15:8];
    bytes[6] = dur[7:0];
    bytes[7] = {7'd0, dur > timeout_ms};
    nres     = NRES_W'(1);
    case (frame)
      FRM_NOTIFY: nres = NRES_W'(NRES);
      FRM_EMPTY: begin
        nres     = NRES_W'(3);
        bytes[1] = EMPTY_CMD;
        bytes[2] = EMPTY_ARG;
      end
      default: nres = NRES_W'(1);
    endcase
    for (int i = 0; i < NRES; i++) begin
      res_load[i].tx_valid       = (frame != FRM_NONE) && (NRES_W'(i) < nres);
      res_load[i].tx_byte        = res_load[i].tx_valid ? bytes[i] : 8'd0;
      res_load[i].tx_last        = (NRES_W'(i) == nres - NRES_W'(1));
      res_load[i].alarm_on       = alarm_level_next;
      res_load[i].door_status    = door_mode_next;
      res_load[i].record_dropped = dropped;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      door_mode      <= MODE_CLOSED;
      open_time      <= '0;
      alarm_level    <= 1'b0;
      rx_position    <= '0;
      rx_second_byte <= '0;
      rx_third_byte  <= '0;
      q_count        <= '0;
    end else if (in_fire) begin
      door_mode      <= door_mode_next;
      open_time      <= open_time_next;
      alarm_level    <= alarm_level_next;
      rx_position    <= rx_position_next;
      rx_second_byte <= rx_second_byte_next;
      rx_third_byte  <= rx_third_byte_next;
      if (push) begin
        q_count <= q_count + QCW'(1);
      end else if (pop) begin
        q_count <= q_count - QCW'(1);
      end
    end
  end

  // duration queue: new entry lands in the first empty cell, pop shifts down
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_q
    cell_ctrl_t  qc;
    logic        up_v;
    logic [15:0] up_d;
    logic        below_full;
    if (i == 0) begin : g_head
      assign below_full = 1'b1;
    end else begin : g_body
      assign below_full = q_vld[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign up_v = 1'b0;
      assign up_d = '0;
    end else begin : g_mid
      assign up_v = q_vld[i+1];
      assign up_d = q_data[i+1];
    end
    assign qc.load  = in_fire && push && !q_vld[i] && below_full;
    assign qc.shift = in_fire && pop;
    dotn_cell #(.W(16)) u_qcell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (qc),
      .load_valid (1'b1),
      .load_data  (dur),
      .up_valid   (up_v),
      .up_data    (up_d),
      .valid      (q_vld[i]),
      .data       (q_data[i])
    );
  end

  // result row: loaded whole on a request, drains toward the output register
  for (genvar i = 0; i < NRES; i++) begin : g_r
    cell_ctrl_t       rc;
    logic             up_v;
    logic [RES_W-1:0] up_d;
    if (i == NRES - 1) begin : g_end
      assign up_v = 1'b0;
      assign up_d = '0;
    end else begin : g_mid
      assign up_v = res_vld[i+1];
      assign up_d = res_data[i+1];
    end
    assign rc.load  = in_fire;
    assign rc.shift = adv;
    dotn_cell #(.W(RES_W)) u_rcell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (rc),
      .load_valid (NRES_W'(i) < nres),
      .load_data  (res_load[i]),
      .up_valid   (up_v),
      .up_data    (up_d),
      .valid      (res_vld[i]),
      .data       (res_data[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res_t'(res_data[0]);
    end
  end

  assign tx_valid       = out_res.tx_valid;
  assign tx_byte        = out_res.tx_byte;
  assign tx_last        = out_res.tx_last;
  assign alarm_on       = out_res.alarm_on;
  assign door_status    = out_res.door_status;
  assign record_dropped = out_res.record_dropped;

  // queue occupancy matches the cell row
  a_qcount: assert property (@(posedge clk) disable iff (rst)
    $countones(q_vld) == q_count)
    else $error("queue count disagrees with occupied cells");

  // queue cells fill from the head without gaps
  a_qpack: assert property (@(posedge clk) disable iff (rst)
    ((q_vld >> 1) & ~q_vld) == '0)
    else $error("gap in queue cell row");

  // result cells fill from the output end without gaps
  a_rpack: assert property (@(posedge clk) disable iff (rst)
    ((res_vld >> 1) & ~res_vld) == '0)
    else $error("gap in result cell row");

  // parser position stays inside a frame
  a_rxpos: assert property (@(posedge clk) disable iff (rst)
    rx_position <= RPW'(RX_FRAME_LEN - 1))
    else $error("receive position beyond frame length");

endmodule

FILE: sv/dotn_cell.sv
// ----------------------------------------------------------------------------
// dotn_cell
// One cell of a shift row: loads a new word or takes its upstream neighbour's.
// ----------------------------------------------------------------------------
module dotn_cell #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  dotn_pkg::cell_ctrl_t ctrl,
  input  logic                load_valid,
  input  logic [W-1:0]        load_data,
  input  logic                up_valid,
  input  logic [W-1:0]        up_data,
  output logic                valid,
  output logic [W-1:0]        data
);
  import dotn_pkg::*;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load) begin
      valid <= load_valid;
    end else if (ctrl.shift) begin
      valid <= up_valid;
    end
  end

  // payload word
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= up_data;
    end
  end

endmodule

FILE: bench/door_open_timeout_notifier_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// door_open_timeout_notifier_top_tb
// Self-checking bench for the door open timeout notifier. Door ticks and
// received bytes are fed through the request channel under several idling
// patterns, and every result is checked against a cycle-free prediction of
// the door modes, duration queue and frame parser.
// ----------------------------------------------------------------------------
module door_open_timeout_notifier_top_tb;
  import dotn_pkg::*;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_RX   = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hFF;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic       kind;
    logic       door_open;
    logic [7:0] rx_byte;
  } door_req_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  kind = KIND_TICK;
  logic                  door_open = 1'b0;
  logic [7:0]            rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  tx_valid;
  logic [7:0]            tx_byte;
  logic                  tx_last;
  logic                  alarm_on;
  logic [1:0]            door_status;
  logic                  record_dropped;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  door_req_t pending_reqs[$];
  res_t      due_results[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      hold_armed = 1'b0;
  logic      rx_hold = 1'b0;
  int        mismatches = 0;
  int        cycle_count = 0;

  // predicted block state
  logic [15:0] mdl_timeout;
  logic        mdl_alarm_en;
  mode_t       mdl_mode;
  logic [15:0] mdl_open_time;
  logic        mdl_alarm;
  logic [15:0] mdl_durations[$];
  int          mdl_rx_pos;
  logic [7:0]  mdl_rx_cmd;
  logic [7:0]  mdl_rx_arg;
  logic [7:0]  pred_frame[$];
  logic        pred_dropped;

  door_open_timeout_notifier_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .door_open      (door_open),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tx_valid       (tx_valid),
    .tx_byte        (tx_byte),
    .tx_last        (tx_last),
    .alarm_on       (alarm_on),
    .door_status    (door_status),
    .record_dropped (record_dropped),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // queue a duration unless the store is full
  function automatic void store_duration(logic [15:0] dur);
    if (mdl_durations.size() >= QUEUE_DEPTH_DEF) begin
      pred_dropped = 1'b1;
    end else begin
      mdl_durations.push_back(dur);
    end
  endfunction

  // notify frame carrying one duration
  function automatic void notify_frame(logic [15:0] dur);
    pred_frame.push_back(SYNC_BYTE);
    pred_frame.push_back(NOTIFY_CMD);
    pred_frame.push_back(NOTIFY_LENH);
    pred_frame.push_back(NOTIFY_LENL);
    pred_frame.push_back(DOOR_ID);
    pred_frame.push_back(dur[15:8]);
    pred_frame.push_back(dur[7:0]);
    pred_frame.push_back({7'd0, dur > mdl_timeout});
  endfunction

  // expected results of one accepted request
  function automatic void predict_door_request(logic k, logic open_s, logic [7:0] b);
    res_t res;
    int   n;
    pred_frame = {};
    pred_dropped = 1'b0;
    if (k == KIND_TICK) begin
      case (mdl_mode)
        MODE_OPEN: begin
          if (mdl_open_time != OPEN_MAX) mdl_open_time = mdl_open_time + 16'd1;
          if (open_s) begin
            if (mdl_open_time > mdl_timeout) begin
              store_duration(mdl_open_time);
              notify_frame(mdl_open_time);
              if (mdl_alarm_en) mdl_alarm = 1'b1;
              mdl_mode = MODE_TIMED;
            end
          end else if (mdl_open_time <= mdl_timeout) begin
            store_duration(mdl_open_time);
            notify_frame(mdl_open_time);
            mdl_mode = MODE_CLOSED;
          end
        end
        MODE_TIMED: begin
          if (!open_s) mdl_mode = MODE_CLOSED;
          mdl_alarm = mdl_alarm_en;
        end
        default: begin
          mdl_mode = MODE_CLOSED;
          if (open_s) begin
            mdl_mode = MODE_OPEN;
            mdl_open_time = 16'd0;
          end
          mdl_alarm = 1'b0;
        end
      endcase
    end else if (mdl_rx_pos == 0) begin
      // hunting for sync
      if (b == SYNC_BYTE) mdl_rx_pos = 1;
    end else begin
      if (mdl_rx_pos == 1) mdl_rx_cmd = b;
      else if (mdl_rx_pos == 2) mdl_rx_arg = b;
      mdl_rx_pos++;
      if (mdl_rx_pos >= RX_FRAME_LEN_DEF) begin
        mdl_rx_pos = 0;
        if (mdl_rx_cmd == REQ_CMD && mdl_rx_arg == REQ_ARG) begin
          if (mdl_durations.size() == 0) begin
            pred_frame.push_back(SYNC_BYTE);
            pred_frame.push_back(EMPTY_CMD);
            pred_frame.push_back(EMPTY_ARG);
          end else begin
            notify_frame(mdl_durations.pop_front());
          end
        end
      end
    end
    // one result per frame byte, or a single empty one
    n = (pred_frame.size() > 0) ? pred_frame.size() : 1;
    for (int i = 0; i < n; i++) begin
      res.tx_valid       = pred_frame.size() > 0;
      res.tx_byte        = (pred_frame.size() > 0) ? pred_frame[i] : 8'h00;
      res.tx_last        = (i == n - 1);
      res.alarm_on       = mdl_alarm;
      res.door_status    = mdl_mode;
      res.record_dropped = pred_dropped;
      due_results.push_back(res);
    end
  endfunction

  // stimulus builders
  function automatic void add_tick(logic open_s);
    pending_reqs.push_back('{KIND_TICK, open_s, 8'($urandom)});
  endfunction

  function automatic void add_rx(logic [7:0] b);
    pending_reqs.push_back('{KIND_RX, 1'($urandom), b});
  endfunction

  // open, stay open for a while, then close
  function automatic void add_episode(int held, int closes);
    add_tick(1'b1);
    repeat (held) add_tick(1'b1);
    repeat (closes) add_tick(1'b0);
  endfunction

  function automatic void add_frame(logic [7:0] cmd, logic [7:0] arg);
    add_rx(SYNC_BYTE);
    add_rx(cmd);
    add_rx(arg);
    for (int i = 3; i < RX_FRAME_LEN_DEF; i++) add_rx(8'($urandom));
  endfunction

  // mostly well-formed door episodes and request frames, some noise
  function automatic void add_random_seq(int span);
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) add_episode($urandom_range(span), $urandom_range(1, 2));
    else if (pick < 70) add_frame(REQ_CMD, REQ_ARG);
    else if (pick < 80) add_frame(8'($urandom), $urandom_range(1) ? REQ_ARG : 8'($urandom));
    else if (pick < 90) add_rx(8'($urandom));
    else add_tick(1'($urandom));
  endfunction

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TIMEOUT) mdl_timeout = val;
    else if (idx == REG_ALARM_EN) mdl_alarm_en = val[0];
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : request_driver
    door_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_door_request(kind, door_open, rx_byte);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          kind      <= nxt.kind;
          door_open <= nxt.door_open;
          rx_byte   <= nxt.rx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    res_t got;
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.tx_valid       = tx_valid;
        got.tx_byte        = tx_byte;
        got.tx_last        = tx_last;
        got.alarm_on       = alarm_on;
        got.door_status    = door_status;
        got.record_dropped = record_dropped;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: valid=%0d byte=%02h last=%0d alarm=%0d st=%0d drop=%0d",
                     got.tx_valid, got.tx_byte, got.tx_last, got.alarm_on,
                     got.door_status, got.record_dropped);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: exp %0d/%02h/%0d/%0d/%0d/%0d got %0d/%02h/%0d/%0d/%0d/%0d",
                       want.tx_valid, want.tx_byte, want.tx_last, want.alarm_on,
                       want.door_status, want.record_dropped,
                       got.tx_valid, got.tx_byte, got.tx_last, got.alarm_on,
                       got.door_status, got.record_dropped);
          end
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : receiver_hold_off
    wait (hold_armed);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // run-length watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int tmo;
    int span;
    mdl_timeout   = TIMEOUT_RESET;
    mdl_alarm_en  = 1'b1;
    mdl_mode      = MODE_CLOSED;
    mdl_open_time = 16'd0;
    mdl_alarm     = 1'b0;
    mdl_rx_pos    = 0;
    mdl_rx_cmd    = 8'h00;
    mdl_rx_arg    = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, hunt noise, empty answer, close in time, timeout, pop
    write_reg(REG_TIMEOUT, 16'd3);
    write_reg(REG_ALARM_EN, 16'd1);
    write_reg(REG_SPARE, 16'hFFFF);
    @(negedge clk);
    add_tick(1'b0);
    add_rx(8'h00);
    add_frame(REQ_CMD, REQ_ARG);
    add_episode(1, 1);
    add_episode(4, 2);
    add_frame(REQ_CMD, REQ_ARG);
    wait_idle();

    // leave the door open, then lower the timeout under it with alarm muted
    write_reg(REG_TIMEOUT, 16'd100);
    @(negedge clk);
    add_episode(5, 0);
    wait_idle();
    write_reg(REG_TIMEOUT, 16'd2);
    write_reg(REG_ALARM_EN, 16'd0);
    @(negedge clk);
    add_tick(1'b0);
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b0);
    wait_idle();

    // overfill the duration store under a receiver hold-off, then pop a few
    write_reg(REG_TIMEOUT, 16'd5);
    write_reg(REG_ALARM_EN, 16'd1);
    @(negedge clk);
    repeat (QUEUE_DEPTH_DEF + 2) add_episode(0, 1);
    repeat (2) add_frame(REQ_CMD, REQ_ARG);
    hold_armed = 1'b1;
    wait_idle();

    // random phases: no idling, sender idle, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      tmo = (p == 0) ? 0 : (p == 3) ? int'(OPEN_MAX) : $urandom_range(1, 12);
      span = (tmo > 16) ? 20 : tmo + 4;
      write_reg(REG_TIMEOUT, tmo[15:0]);
      write_reg(REG_ALARM_EN, 16'($urandom_range(1)));
      @(negedge clk);
      send_idle_pct  = (p == 1) ? 79 : (p == 3) ? 23 : 0;
      recv_stall_pct = (p == 2) ? 79 : (p == 3) ? 23 : 0;
      while (pending_reqs.size() < 55) add_random_seq(span);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
